### design/elc_pkg.sv
// Shared constants, types and helper functions for the longitude converter.
package elc_pkg;

   typedef logic signed [31:0] angle_type;
   typedef logic signed [35:0] wide_type;

   // Q4.28 and Q2.30 angle constants
   localparam wide_type TWO_PI_Q28  = 36'sd1686629713;
   localparam wide_type PI_Q28      = 36'sd843314857;
   localparam wide_type PI_Q30      = 36'sd3373259426;
   localparam wide_type HALF_PI_Q30 = 36'sd1686629713;
   localparam wide_type CORDIC_GAIN = 36'sd652032874;
   localparam wide_type UNIT_Q30    = 36'sd1073741824;

   localparam int CORDIC_STEPS = 31;
   localparam int MAX_NEWTON_STEPS_DEF = 1000;
   localparam logic [15:0] TOL_RESET = 16'd4;

   // divider operand widths: |residual| << 30 over |slope|
   localparam int DIV_NUM_W = 62;
   localparam int DIV_DEN_W = 35;

   // request codes
   localparam logic [1:0] REQ_M2M = 2'd0;
   localparam logic [1:0] REQ_M2E = 2'd1;
   localparam logic [1:0] REQ_E2M = 2'd2;
   localparam logic [1:0] REQ_E2E = 2'd3;

   // atan(2^-i) in Q2.30, rounded
   function automatic logic [30:0] atan_q30(input logic [4:0] idx);
      logic [30:0] val;
      case (idx)
         5'd0:    val = 31'd843314857;
         5'd1:    val = 31'd497837829;
         5'd2:    val = 31'd263043837;
         5'd3:    val = 31'd133525159;
         5'd4:    val = 31'd67021687;
         5'd5:    val = 31'd33543516;
         5'd6:    val = 31'd16775851;
         5'd7:    val = 31'd8388437;
         5'd8:    val = 31'd4194283;
         5'd9:    val = 31'd2097149;
         default: val = 31'd1 << (5'd30 - idx);
      endcase
      return val;
   endfunction

   // clamp to +-1.0 in Q2.30
   function automatic angle_type clamp_unit(input wide_type v);
      angle_type r;
      if (v > UNIT_Q30)       r = 32'sd1073741824;
      else if (v < -UNIT_Q30) r = -32'sd1073741824;
      else                    r = v[31:0];
      return r;
   endfunction

   // saturate to the signed 32-bit range
   function automatic angle_type sat32(input logic signed [65:0] v);
      angle_type r;
      if (v > 66'sd2147483647)       r = 32'sh7fffffff;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else                           r = v[31:0];
      return r;
   endfunction

endpackage

### design/equinoctial_longitude_converter_top.sv
// Top level: mean/eccentric longitude converter with a Newton solver.
//
// An item is taken when start is high and busy is low; its result shows on the
// rsp_ ports for one cycle, marked by rsp_valid, and cannot be held off.
// Identity requests answer in the cycle after the item is taken and never raise busy.
// Eccentric to mean keeps busy high through angle reduction (one 2pi add or
// subtract a cycle, before and after the pass), a pass of the shared CORDIC
// unit (start, 31 rotations, output, handoff), the shared multiplier and a
// step to form the term. Mean to eccentric forms its start value the same
// way, then for each Newton step one more reduction and CORDIC pass, the
// products, residual and slope, and a run of the bit-serial divider (62
// quotient bits), skipped when the slope is zero, for up to MAX_NEWTON_STEPS
// steps. busy stays high for the whole item.
module equinoctial_longitude_converter_top import elc_pkg::*; #(
   parameter int MAX_NEWTON_STEPS = MAX_NEWTON_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  angle_type   req_longitude_in,
   input  angle_type   req_h_component,
   input  angle_type   req_k_component,
   output logic        rsp_valid,
   output angle_type   rsp_longitude_out,
   output logic        rsp_status,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int ITER_W = $clog2(MAX_NEWTON_STEPS + 1);

   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_WRAP = 4'd1;
   localparam logic [3:0] S_CORD = 4'd2;
   localparam logic [3:0] S_MUL  = 4'd3;
   localparam logic [3:0] S_TERM = 4'd4;
   localparam logic [3:0] S_NEWT = 4'd5;
   localparam logic [3:0] S_STEP = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_UPD  = 4'd8;

   // what the current pass computes
   localparam logic [1:0] PH_E2M_TERM  = 2'd0;
   localparam logic [1:0] PH_E2M_FINAL = 2'd1;
   localparam logic [1:0] PH_M2E_START = 2'd2;
   localparam logic [1:0] PH_M2E_NEWT  = 2'd3;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] tol_ff, tol_in;
   logic [2:0]  mcnt_ff, mcnt_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic        cstart_ff, cstart_in;
   logic        dstart_ff, dstart_in;
   logic        rv_ff, rv_in;
   logic        rs_ff, rs_in;
   angle_type   rl_ff, rl_in;
   angle_type   lon_ff, lon_in, h_ff, h_in, k_ff, k_in, f_ff, f_in;
   wide_type    red_ff, red_in;
   wide_type    ks_ff, ks_in, hc_ff, hc_in, kc_ff, kc_in, hs_ff, hs_in;
   wide_type    v_ff, v_in, slope_ff, slope_in;
   logic        conv_ff, conv_in;
   logic        neg_ff, neg_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic signed [63:0]   step_ff, step_in;
   logic signed [63:0]   prod_ff, prod_in;

   logic        cdone, ddone;
   angle_type   sin_v, cos_v;
   logic [DIV_NUM_W-1:0] quot;

   angle_type   ma, mb, vs, fsat;
   logic signed [64:0] rnd32, rnd30;
   wide_type    term, lon_w, f_w, av;
   logic signed [65:0] fnew;

   elc_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cstart_ff),
      .angle   (red_ff[31:0]),
      .done    (cdone),
      .sin_out (sin_v),
      .cos_out (cos_v)
   );

   elc_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (dstart_ff),
      .numer (num_ff),
      .denom (den_ff),
      .done  (ddone),
      .quot  (quot)
   );

   always_comb begin
      // shared multiplier operand select
      case (mcnt_ff)
         3'd0:    begin ma = k_ff; mb = sin_v; end
         3'd1:    begin ma = h_ff; mb = cos_v; end
         3'd2:    begin ma = k_ff; mb = cos_v; end
         default: begin ma = h_ff; mb = sin_v; end
      endcase
      rnd32 = ($signed({prod_ff[63], prod_ff}) + 65'sd2147483648) >>> 32;
      rnd30 = ($signed({prod_ff[63], prod_ff}) + 65'sd536870912) >>> 30;
      lon_w = {{4{lon_ff[31]}}, lon_ff};
      f_w   = {{4{f_ff[31]}}, f_ff};
      term  = f_w - ks_ff + hc_ff;
      vs    = sat32({{30{v_ff[35]}}, v_ff});
      av    = v_ff[35] ? -v_ff : v_ff;
      fnew  = {{34{f_ff[31]}}, f_ff} - {{2{step_ff[63]}}, step_ff};
      fsat  = sat32(fnew);

      state_in  = state_ff;
      phase_in  = phase_ff;
      tol_in    = csr_we ? csr_wdata : tol_ff;
      mcnt_in   = mcnt_ff;
      iter_in   = iter_ff;
      cstart_in = 1'b0;
      dstart_in = 1'b0;
      rv_in     = 1'b0;
      rs_in     = rs_ff;
      rl_in     = rl_ff;
      lon_in    = lon_ff;
      h_in      = h_ff;
      k_in      = k_ff;
      f_in      = f_ff;
      red_in    = red_ff;
      ks_in     = ks_ff;
      hc_in     = hc_ff;
      kc_in     = kc_ff;
      hs_in     = hs_ff;
      v_in      = v_ff;
      slope_in  = slope_ff;
      conv_in   = conv_ff;
      neg_in    = neg_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      step_in   = step_ff;
      prod_in   = ma * mb;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               lon_in  = req_longitude_in;
               h_in    = req_h_component;
               k_in    = req_k_component;
               f_in    = req_longitude_in;
               red_in  = {{4{req_longitude_in[31]}}, req_longitude_in};
               iter_in = '0;
               if (req_type == REQ_M2M || req_type == REQ_E2E) begin
                  rv_in = 1'b1;
                  rl_in = req_longitude_in;
                  rs_in = 1'b0;
               end else begin
                  phase_in = (req_type == REQ_E2M) ? PH_E2M_TERM : PH_M2E_START;
                  state_in = S_WRAP;
               end
            end
         end
         // reduce red into [0, 2pi), then give the result or start the CORDIC
         S_WRAP: begin
            if (red_ff[35]) begin
               red_in = red_ff + TWO_PI_Q28;
            end else if (red_ff >= TWO_PI_Q28) begin
               red_in = red_ff - TWO_PI_Q28;
            end else if (phase_ff == PH_E2M_FINAL) begin
               rv_in    = 1'b1;
               rl_in    = red_ff[31:0];
               rs_in    = 1'b0;
               state_in = S_IDLE;
            end else begin
               cstart_in = 1'b1;
               state_in  = S_CORD;
            end
         end
         S_CORD: begin
            if (cdone) begin
               mcnt_in  = 3'd0;
               state_in = S_MUL;
            end
         end
         // one product per cycle, rounded and stored in the cycle after
         S_MUL: begin
            case (mcnt_ff)
               3'd1:    ks_in = rnd32[35:0];
               3'd2:    hc_in = rnd32[35:0];
               3'd3:    kc_in = rnd30[35:0];
               3'd4:    hs_in = rnd30[35:0];
               default: ;
            endcase
            mcnt_in = mcnt_ff + 3'd1;
            if (mcnt_ff == 3'd4) state_in = S_TERM;
         end
         S_TERM: begin
            case (phase_ff)
               PH_E2M_TERM: begin
                  red_in   = term;
                  phase_in = PH_E2M_FINAL;
                  state_in = S_WRAP;
               end
               PH_M2E_START: begin
                  f_in     = sat32({{30{term[35]}}, term});
                  red_in   = {{4{f_in[31]}}, f_in};
                  phase_in = PH_M2E_NEWT;
                  state_in = S_WRAP;
               end
               default: state_in = S_NEWT;
            endcase
         end
         // residual and slope
         S_NEWT: begin
            v_in     = term - lon_w;
            slope_in = UNIT_Q30 - kc_ff - hs_ff;
            state_in = S_STEP;
         end
         S_STEP: begin
            conv_in = av < {20'd0, tol_ff};
            if (slope_ff == '0) begin
               if (vs > 0)      step_in = 64'sd4294967296;
               else if (vs < 0) step_in = -64'sd4294967296;
               else             step_in = '0;
               state_in = S_UPD;
            end else begin
               num_in    = {(vs[31] ? 32'(-vs) : 32'(vs)), 30'd0};
               den_in    = slope_ff[35] ? 35'(-slope_ff) : 35'(slope_ff);
               neg_in    = vs[31] ^ slope_ff[35];
               dstart_in = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (ddone) begin
               step_in  = neg_ff ? -{2'b00, quot} : {2'b00, quot};
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            f_in = fsat;
            if (conv_ff) begin
               rv_in    = 1'b1;
               rl_in    = fsat;
               rs_in    = 1'b0;
               state_in = S_IDLE;
            end else if (iter_ff == ITER_W'(MAX_NEWTON_STEPS - 1)) begin
               rv_in    = 1'b1;
               rl_in    = '0;
               rs_in    = 1'b1;
               state_in = S_IDLE;
            end else begin
               iter_in  = iter_ff + 1'b1;
               red_in   = {{4{fsat[31]}}, fsat};
               state_in = S_WRAP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         tol_ff    <= TOL_RESET;
         cstart_ff <= 1'b0;
         dstart_ff <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tol_ff    <= tol_in;
         cstart_ff <= cstart_in;
         dstart_ff <= dstart_in;
         rv_ff     <= rv_in;
      end
      phase_ff <= phase_in;
      mcnt_ff  <= mcnt_in;
      iter_ff  <= iter_in;
      rs_ff    <= rs_in;
      rl_ff    <= rl_in;
      lon_ff   <= lon_in;
      h_ff     <= h_in;
      k_ff     <= k_in;
      f_ff     <= f_in;
      red_ff   <= red_in;
      ks_ff    <= ks_in;
      hc_ff    <= hc_in;
      kc_ff    <= kc_in;
      hs_ff    <= hs_in;
      v_ff     <= v_in;
      slope_ff <= slope_in;
      conv_ff  <= conv_in;
      neg_ff   <= neg_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      step_ff  <= step_in;
      prod_ff  <= prod_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rv_ff;
   assign rsp_longitude_out = rl_ff;
   assign rsp_status        = rs_ff;

endmodule

### design/elc_cordic.sv
// Iterative CORDIC sine/cosine unit, one rotation per cycle.
module elc_cordic import elc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  angle_type angle,
   output logic      done,
   output angle_type sin_out,
   output angle_type cos_out
);

   logic      run_ff, run_in;
   logic      done_ff, done_in;
   logic [4:0] idx_ff, idx_in;
   wide_type  x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic      neg_ff, neg_in;
   angle_type sin_ff, sin_in, cos_ff, cos_in;

   wide_type  ang_w, r_w, z4, z0, xs, ys, at, xf;
   logic      neg0;

   // range reduction and quadrant fold for the start value
   always_comb begin
      ang_w = {{4{angle[31]}}, angle};
      r_w   = (ang_w >= PI_Q28) ? ang_w - TWO_PI_Q28 : ang_w;
      z4    = r_w <<< 2;
      neg0  = 1'b0;
      z0    = z4;
      if (z4 > HALF_PI_Q30) begin
         z0   = PI_Q30 - z4;
         neg0 = 1'b1;
      end else if (z4 < -HALF_PI_Q30) begin
         z0   = -PI_Q30 - z4;
         neg0 = 1'b1;
      end
   end

   // start, one rotation step, and the clamped output
   always_comb begin
      xs      = x_ff >>> idx_ff;
      ys      = y_ff >>> idx_ff;
      at      = {5'd0, atan_q30(idx_ff)};
      xf      = neg_ff ? -x_ff : x_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      idx_in  = idx_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      neg_in  = neg_ff;
      sin_in  = sin_ff;
      cos_in  = cos_ff;
      if (start) begin
         run_in = 1'b1;
         idx_in = 5'd0;
         x_in   = CORDIC_GAIN;
         y_in   = '0;
         z_in   = z0;
         neg_in = neg0;
      end else if (run_ff) begin
         if (idx_ff == 5'(CORDIC_STEPS)) begin
            cos_in  = clamp_unit(xf);
            sin_in  = clamp_unit(y_ff);
            done_in = 1'b1;
            run_in  = 1'b0;
         end else begin
            if (!z_ff[35]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end
            idx_in = idx_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      idx_ff <= idx_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign done    = done_ff;
   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

### design/elc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module elc_div import elc_pkg::*; #(
   parameter int NUM_W = DIV_NUM_W,
   parameter int DEN_W = DIV_DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem_sh, diff;

   always_comb begin
      rem_sh  = {rem_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      diff    = rem_sh - {1'b0, den_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         q_in   = numer;
         rem_in = '0;
         den_in = denom;
      end else if (run_ff) begin
         // shift in next numerator bit, subtract when it fits
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = diff;
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

### verif/equinoctial_longitude_converter_top_tb.sv
// Self-checking testbench for the mean/eccentric longitude converter.
module equinoctial_longitude_converter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import elc_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1300;
   localparam longint TWO_PI = 64'sd1686629713;
   localparam longint PI_28 = 64'sd843314857;
   localparam longint PI_30 = 64'sd3373259426;
   localparam longint HALF_PI = 64'sd1686629713;
   localparam longint ONE_Q30 = 64'sd1 << 30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = REQ_M2M;
   angle_type   req_longitude_in = '0;
   angle_type   req_h_component = '0;
   angle_type   req_k_component = '0;
   logic        rsp_valid;
   angle_type   rsp_longitude_out;
   logic        rsp_status;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   typedef struct packed {
      logic [31:0] lon;
      logic        status;
   } conv_result_type;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] lon;
      logic [31:0] h;
      logic [31:0] k;
      logic [16:0] tol;       // bit 16 set: leave tolerance alone
      bit          typed;     // expected result given in the row
      logic [31:0] exp_lon;
      logic        exp_status;
   } stim_row_type;

   conv_result_type pending_results[$];
   longint       atan_q30_tab[31];
   logic [15:0]  tol_model;
   int           errors = 0;
   int           items_sent = 0;
   int           results_seen = 0;
   int           nonconv_seen = 0;
   int           idle_cycles = 0;
   int           wild_m2e = 0;

   always #5 clock = ~clock;

   equinoctial_longitude_converter_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_longitude_in(req_longitude_in),
      .req_h_component(req_h_component), .req_k_component(req_k_component),
      .rsp_valid(rsp_valid), .rsp_longitude_out(rsp_longitude_out),
      .rsp_status(rsp_status), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // atan(2^-i) from its series in Q60, rounded to Q30
   function automatic void build_atan_table();
      longint unsigned acc, term;
      atan_q30_tab[0] = PI_28;
      for (int i = 1; i < 31; i++) begin
         acc = 0;
         for (int n = 0; i * (2 * n + 1) < 61; n++) begin
            term = (64'd1 << 60) >> (i * (2 * n + 1));
            term = term / (2 * n + 1);
            if (n % 2) acc = acc - term;
            else acc = acc + term;
         end
         atan_q30_tab[i] = longint'((acc + (64'd1 << 29)) >> 30);
      end
   endfunction

   function automatic longint sat_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint clamp_one(longint v);
      if (v > ONE_Q30) return ONE_Q30;
      if (v < -ONE_Q30) return -ONE_Q30;
      return v;
   endfunction

   function automatic longint mul_round(longint a, longint b, int sh);
      return (a * b + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint wrap_angle(longint a);
      longint r;
      r = a % TWO_PI;
      if (r < 0) r += TWO_PI;
      return r;
   endfunction

   // CORDIC sine and cosine in Q2.30
   task automatic cordic_sin_cos(input longint ang, output longint s, output longint c);
      longint r, z, x, y, nx;
      bit flip;
      x = 652032874;
      y = 0;
      flip = 0;
      r = wrap_angle(ang);
      if (r >= PI_28) r -= TWO_PI;
      z = r * 4;
      if (z > HALF_PI) begin
         z = PI_30 - z;
         flip = 1;
      end else if (z < -HALF_PI) begin
         z = -PI_30 - z;
         flip = 1;
      end
      for (int i = 0; i < 31; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); z -= atan_q30_tab[i];
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); z += atan_q30_tab[i];
         end
         x = nx;
      end
      c = clamp_one(flip ? -x : x);
      s = clamp_one(y);
   endtask

   // expected conversion of one item
   task automatic convert_longitude(input logic [1:0] kind, input logic [31:0] lon_b,
                                    input logic [31:0] h_b, input logic [31:0] k_b,
                                    output conv_result_type res);
      longint lon, h, k, f, s, c, v, vs, slope, stp, av, out;
      bit done;
      lon = longint'(signed'(lon_b));
      h = longint'(signed'(h_b));
      k = longint'(signed'(k_b));
      out = lon;
      res.status = 1'b0;
      if (kind == REQ_E2M) begin
         cordic_sin_cos(lon, s, c);
         out = wrap_angle(lon - mul_round(k, s, 32) + mul_round(h, c, 32));
      end else if (kind == REQ_M2E) begin
         cordic_sin_cos(lon, s, c);
         f = sat_word(lon - mul_round(k, s, 32) + mul_round(h, c, 32));
         done = 0;
         for (int i = 0; i < 1000 && !done; i++) begin
            cordic_sin_cos(f, s, c);
            v = f - mul_round(k, s, 32) + mul_round(h, c, 32) - lon;
            slope = ONE_Q30 - mul_round(k, c, 30) - mul_round(h, s, 30);
            vs = sat_word(v);
            if (slope != 0) stp = (vs * ONE_Q30) / slope;
            else stp = vs > 0 ? (64'sd1 << 32) : (vs < 0 ? -(64'sd1 << 32) : 0);
            f = sat_word(f - stp);
            av = v < 0 ? -v : v;
            if (av < longint'(tol_model)) done = 1;
         end
         if (done) out = f;
         else begin
            out = 0;
            res.status = 1'b1;
         end
      end
      res.lon = out[31:0];
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen++;
         if (rsp_status) nonconv_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result lon=%h status=%b", $realtime,
                     rsp_longitude_out, rsp_status);
            errors++;
         end else begin
            if (rsp_longitude_out !== pending_results[0].lon) begin
               $display("%0t: longitude expected %h actual %h", $realtime,
                        pending_results[0].lon, rsp_longitude_out);
               errors++;
            end
            if (rsp_status !== pending_results[0].status) begin
               $display("%0t: status expected %b actual %b", $realtime,
                        pending_results[0].status, rsp_status);
               errors++;
            end
            void'(pending_results.pop_front());
         end
      end
   end

   // watchdog on cycles with no traffic
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $realtime);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // wait for all results, then let the block settle
   task automatic drain();
      while (pending_results.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [15:0] val);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= val;
      tol_model = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // drive one item; start stays high across back-to-back items
   task automatic send_item(input logic [1:0] kind, input logic [31:0] lon,
                            input logic [31:0] h, input logic [31:0] k,
                            input bit typed, input conv_result_type typed_res);
      int gap;
      conv_result_type res;
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0 && start) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end else if (gap > 0) repeat (gap) @(posedge clock);
      start <= 1'b1;
      req_type <= kind;
      req_longitude_in <= lon;
      req_h_component <= h;
      req_k_component <= k;
      do @(posedge clock); while (busy);
      convert_longitude(kind, lon, h, k, res);
      if (typed && res !== typed_res) begin
         $display("%0t: table row disagrees with predictor: %h vs %h", $realtime,
                  typed_res, res);
         errors++;
      end
      pending_results.push_back(res);
      items_sent++;
   endtask

   task automatic stop_items();
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] small_elem();
      return 32'($signed($urandom_range(0, 1288490188)) - 644245094);
   endfunction

   stim_row_type directed_rows[$];
   stim_row_type row;
   conv_result_type typed_res;
   logic [1:0] kind;
   logic [31:0] h_r, k_r;
   logic [15:0] tol_pick;

   function automatic stim_row_type mk(logic [1:0] kd, logic [31:0] ln, logic [31:0] hh,
                                       logic [31:0] kk, logic [16:0] tl, bit ty,
                                       logic [31:0] el, logic es);
      stim_row_type r;
      r.kind = kd; r.lon = ln; r.h = hh; r.k = kk; r.tol = tl;
      r.typed = ty; r.exp_lon = el; r.exp_status = es;
      return r;
   endfunction

   initial begin
      build_atan_table();
      tol_model = TOL_RESET;
      // directed table: identities, extremes, zero slope, zero tolerance
      directed_rows.push_back(mk(REQ_M2M, 32'h80000000, 32'h7fffffff, 32'h80000000,
                                 17'h10000, 1, 32'h80000000, 0));
      directed_rows.push_back(mk(REQ_E2E, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                 17'h10000, 1, 32'h7fffffff, 0));
      directed_rows.push_back(mk(REQ_M2M, 32'h0, 32'h0, 32'h0, 17'h10000, 1, 32'h0, 0));
      directed_rows.push_back(mk(REQ_E2E, 32'hffffffff, 32'h0, 32'h0, 17'h10000, 1,
                                 32'hffffffff, 0));
      directed_rows.push_back(mk(REQ_E2M, 32'h0, 32'h0, 32'h0, 17'h10000, 1, 32'h0, 0));
      directed_rows.push_back(mk(REQ_E2M, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                 17'h10000, 0, 0, 0));
      directed_rows.push_back(mk(REQ_E2M, 32'h80000000, 32'h80000000, 32'h80000000,
                                 17'h10000, 0, 0, 0));
      directed_rows.push_back(mk(REQ_E2M, 32'd843314857, 32'd214748364, 32'hf3333334,
                                 17'h10000, 0, 0, 0));
      directed_rows.push_back(mk(REQ_M2E, 32'h0, 32'h0, 32'h0, 17'h10000, 1, 32'h0, 0));
      directed_rows.push_back(mk(REQ_M2E, 32'd421657428, 32'd107374182, 32'd322122547,
                                 17'h10000, 0, 0, 0));
      directed_rows.push_back(mk(REQ_M2E, 32'hf0000000, 32'hf3333334, 32'd429496729,
                                 17'h10000, 0, 0, 0));
      directed_rows.push_back(mk(REQ_M2E, 32'h7fffffff, 32'd0, 32'd536870912,
                                 17'h10000, 0, 0, 0));
      // k = 1.0 at angle 0 gives a zero slope
      directed_rows.push_back(mk(REQ_M2E, 32'd100, 32'd0, 32'h40000000,
                                 17'h10000, 0, 0, 0));
      directed_rows.push_back(mk(REQ_M2E, 32'h80000000, 32'd0, 32'd0, 17'h10000, 0, 0, 0));
      // zero tolerance never converges
      directed_rows.push_back(mk(REQ_M2E, 32'd268435456, 32'd0, 32'd0, 17'h00000, 1,
                                 32'h0, 1));
      directed_rows.push_back(mk(REQ_E2M, 32'd268435456, 32'd0, 32'd0, 17'h10000, 0, 0, 0));
      directed_rows.push_back(mk(REQ_M2E, 32'd268435456, 32'd53687091, 32'd53687091,
                                 17'h0ffff, 0, 0, 0));
      directed_rows.push_back(mk(REQ_M2E, 32'hc0000000, 32'd0, 32'd107374182,
                                 17'h00001, 0, 0, 0));
      directed_rows.push_back(mk(REQ_M2M, 32'h12345678, 32'h0, 32'h0, 17'h10000, 1,
                                 32'h12345678, 0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (!row.tol[16]) begin
            stop_items();
            write_tolerance(row.tol[15:0]);
         end
         typed_res.lon = row.exp_lon;
         typed_res.status = row.exp_status;
         send_item(row.kind, row.lon, row.h, row.k, row.typed, typed_res);
      end

      // random phases, each with its own tolerance
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: tol_pick = 16'd4;
            1: tol_pick = 16'hffff;
            2: tol_pick = 16'd16;
            3: tol_pick = 16'd1;
            default: tol_pick = 16'($urandom_range(8, 1000));
         endcase
         stop_items();
         write_tolerance(tol_pick);
         for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
            kind = 2'($urandom_range(0, 3));
            if (ph == 3 && kind == REQ_M2E && $urandom_range(0, 3) != 0) kind = REQ_E2M;
            h_r = small_elem();
            k_r = small_elem();
            case ($urandom_range(0, 19))
               0: begin
                  h_r = 0; k_r = 0;
               end
               1, 2: begin
                  // wild elements: rarely on the Newton path
                  if (kind != REQ_M2E || wild_m2e < 3) begin
                     if (kind == REQ_M2E) wild_m2e++;
                     h_r = $urandom; k_r = $urandom;
                  end
               end
               default: ;
            endcase
            typed_res = '0;
            send_item(kind, $urandom, h_r, k_r, 0, typed_res);
         end
      end

      stop_items();
      drain();
      repeat (20) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $realtime, pending_results.size());
         errors++;
      end
      $display("Sent %0d items over several tolerance settings; %0d results, %0d unconverged.",
               items_sent, results_seen, nonconv_seen);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
